// ===== hdl/teadec_pkg.sv =====
// Package: TEA decrypt constants, stage type and round-sum function.
`timescale 1ns / 1ps
`default_nettype none
package teadec_pkg;
	localparam int ROUNDS = 32;
	localparam int CELLS = 2 * ROUNDS;
	localparam int WORD_W = 32;
	localparam int BLOCK_W = 2 * WORD_W;
	localparam int CFG_IDX_W = 2;

	localparam logic [WORD_W-1:0] TEA_DELTA = 32'h9E3779B9;

	localparam logic [WORD_W-1:0] KEY0_RST = 32'd2510780204;
	localparam logic [WORD_W-1:0] KEY1_RST = 32'd2636955923;
	localparam logic [WORD_W-1:0] KEY2_RST = 32'd1901764813;
	localparam logic [WORD_W-1:0] KEY3_RST = 32'd2714008055;

	localparam logic [CFG_IDX_W-1:0] REG_KEY0 = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_KEY1 = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_KEY2 = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_KEY3 = 2'd3;

	typedef struct packed {
		logic [WORD_W-1:0] a;
		logic [WORD_W-1:0] b;
		logic              last;
	} stage_t;

	// running sum used in round r (counting from zero)
	function automatic logic [WORD_W-1:0] round_sum(input int r);
		logic [WORD_W-1:0] cnt;
		cnt = WORD_W'(ROUNDS - r);
		return cnt * TEA_DELTA;
	endfunction
endpackage
`default_nettype wire

// ===== hdl/teadec_in_if.sv =====
// Interface: ciphertext input channel.
`timescale 1ns / 1ps
`default_nettype none
interface teadec_in_if;
	logic        valid;
	logic        ready;
	logic [63:0] cipher_block;
	logic        last_block;

	modport source (output valid, output cipher_block, output last_block, input ready);
	modport sink (input valid, input cipher_block, input last_block, output ready);
endinterface
`default_nettype wire

// ===== hdl/teadec_out_if.sv =====
// Interface: plaintext output channel.
`timescale 1ns / 1ps
`default_nettype none
interface teadec_out_if;
	logic        valid;
	logic        ready;
	logic [63:0] plain_block;
	logic        last_out;

	modport source (output valid, output plain_block, output last_out, input ready);
	modport sink (input valid, input plain_block, input last_out, output ready);
endinterface
`default_nettype wire

// ===== hdl/teadec_cell.sv =====
// Half-round cell: updates one word from the other and swaps the pair.
`timescale 1ns / 1ps
`default_nettype none
module teadec_cell (
	input  wire                        clk,
	input  wire                        arst_n,
	input  wire                        advance,
	input  wire                        up_valid,
	input  wire teadec_pkg::stage_t    up_stage,
	input  wire [teadec_pkg::WORD_W-1:0] sum_c,
	input  wire [teadec_pkg::WORD_W-1:0] key_hi,
	input  wire [teadec_pkg::WORD_W-1:0] key_lo,
	output logic                       dn_valid,
	output teadec_pkg::stage_t         dn_stage
);
	import teadec_pkg::*;

	logic [WORD_W-1:0] mix;
	stage_t            nxt;
	logic              valid_s1;
	stage_t            stage_s1;

	always_comb begin
		mix = ((up_stage.a << 4) + key_hi) ^ (up_stage.a + sum_c) ^ ((up_stage.a >> 5) + key_lo);
		nxt.a = up_stage.b - mix;
		nxt.b = up_stage.a;
		nxt.last = up_stage.last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			stage_s1 <= nxt;
		end
	end

	assign dn_valid = valid_s1;
	assign dn_stage = stage_s1;
endmodule
`default_nettype wire

// ===== hdl/tea_block_decrypt_core.sv =====
// Top level: TEA block decryptor, one half-round per cell in a chain.
//
// Usage:
//   in_ch carries one 64-bit ciphertext beat (first memory byte in bits 63..56,
//   v0 in the upper word) plus a last flag. out_ch returns the decrypted beat
//   in the same byte order with the flag copied through.
//   Blocks are independent (ECB); result order equals input order.
//   The chain has 2*ROUNDS cells (64 for 32 rounds), one half-round each, and
//   one beat is taken every cycle while the output side keeps up.
//   The last cell is the output register. If out_ch stalls with a valid beat,
//   the whole chain holds and in_ch.ready drops; bubbles in flight are not
//   squeezed out.
//   Keys are written through cfg_we/cfg_index/cfg_data; the user must write
//   them only while the chain is empty, which the block does not check.
//   Reset empties the chain and loads the default key words.
`timescale 1ns / 1ps
`default_nettype none
module tea_block_decrypt_core (
	input  wire                           clk,
	input  wire                           arst_n,
	teadec_in_if.sink                     in_ch,
	teadec_out_if.source                  out_ch,
	input  wire                           cfg_we,
	input  wire [teadec_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire [teadec_pkg::WORD_W-1:0]  cfg_data
);
	import teadec_pkg::*;

	logic [WORD_W-1:0] key0_q, key1_q, key2_q, key3_q;
	logic              chain_valid [0:CELLS];
	stage_t            chain_stage [0:CELLS];
	logic              advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key0_q <= KEY0_RST;
			key1_q <= KEY1_RST;
			key2_q <= KEY2_RST;
			key3_q <= KEY3_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_KEY0: key0_q <= cfg_data;
				REG_KEY1: key1_q <= cfg_data;
				REG_KEY2: key2_q <= cfg_data;
				REG_KEY3: key3_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign advance = !chain_valid[CELLS] || out_ch.ready;
	assign in_ch.ready = advance;

	assign chain_valid[0] = in_ch.valid;
	assign chain_stage[0] = {in_ch.cipher_block, in_ch.last_block};

	for (genvar i = 0; i < CELLS; i++) begin : g_cell
		localparam logic [WORD_W-1:0] SUM_C = round_sum(i / 2);
		logic [WORD_W-1:0] key_hi, key_lo;
		if ((i % 2) == 0) begin : g_even
			assign key_hi = key2_q;
			assign key_lo = key3_q;
		end else begin : g_odd
			assign key_hi = key0_q;
			assign key_lo = key1_q;
		end
		teadec_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.advance  (advance),
			.up_valid (chain_valid[i]),
			.up_stage (chain_stage[i]),
			.sum_c    (SUM_C),
			.key_hi   (key_hi),
			.key_lo   (key_lo),
			.dn_valid (chain_valid[i+1]),
			.dn_stage (chain_stage[i+1])
		);
	end

	assign out_ch.valid = chain_valid[CELLS];
	assign out_ch.plain_block = {chain_stage[CELLS].a, chain_stage[CELLS].b};
	assign out_ch.last_out = chain_stage[CELLS].last;
endmodule
`default_nettype wire

// ===== sim/tb_tea_block_decrypt_core.sv =====
// Testbench: TEA block decrypt core, directed and random beats checked against a predictor.
`timescale 1ns / 1ps
module tb_tea_block_decrypt_core;
	import teadec_pkg::*;

	localparam int IDLE_PCT = 36;
	localparam int PHASE_BEATS = 250;
	localparam int PHASES = 5;
	localparam int MAX_REPORTS = 10;
	localparam int LIMIT_CYCLES = 400000;

	typedef enum logic {ROW_BEAT, ROW_KEY} row_kind_e;

	typedef struct {
		row_kind_e            kind;
		logic [CFG_IDX_W-1:0] key_idx;
		logic [BLOCK_W-1:0]   value;
		logic                 last;
	} stim_row_t;

	typedef struct {
		logic [BLOCK_W-1:0] plain;
		logic               last;
	} plain_beat_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [WORD_W-1:0] cfg_data;

	teadec_in_if in_ch ();
	teadec_out_if out_ch ();

	tea_block_decrypt_core i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (in_ch),
		.out_ch    (out_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	logic [WORD_W-1:0] key_word [4];
	plain_beat_t plain_q [$];
	bit calm;
	int blocks_sent;
	int blocks_checked;
	int key_writes;
	int key_sets;
	int mismatches;

	stim_row_t directed [] = '{
		'{ROW_BEAT, REG_KEY0, 64'h0000_0000_0000_0000, 1'b0},
		'{ROW_BEAT, REG_KEY0, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1},
		'{ROW_BEAT, REG_KEY0, 64'h8000_0000_0000_0000, 1'b0},
		'{ROW_BEAT, REG_KEY0, 64'h0000_0000_0000_0001, 1'b1},
		'{ROW_BEAT, REG_KEY0, 64'hFFFF_FFFF_0000_0000, 1'b0},
		'{ROW_BEAT, REG_KEY0, 64'h0000_0000_FFFF_FFFF, 1'b0},
		'{ROW_BEAT, REG_KEY0, 64'hAAAA_AAAA_AAAA_AAAA, 1'b1},
		'{ROW_BEAT, REG_KEY0, 64'h5555_5555_5555_5555, 1'b0},
		'{ROW_BEAT, REG_KEY0, 64'h0123_4567_89AB_CDEF, 1'b1},
		'{ROW_KEY,  REG_KEY0, 64'h0000_0000_0000_0000, 1'b0},
		'{ROW_KEY,  REG_KEY1, 64'h0000_0000_0000_0000, 1'b0},
		'{ROW_KEY,  REG_KEY2, 64'h0000_0000_0000_0000, 1'b0},
		'{ROW_KEY,  REG_KEY3, 64'h0000_0000_0000_0000, 1'b0},
		'{ROW_BEAT, REG_KEY0, 64'h0000_0000_0000_0000, 1'b0},
		'{ROW_BEAT, REG_KEY0, 64'h41EA_3A0A_94BA_A940, 1'b1},
		'{ROW_BEAT, REG_KEY0, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0},
		'{ROW_KEY,  REG_KEY0, 64'h0000_0000_FFFF_FFFF, 1'b0},
		'{ROW_KEY,  REG_KEY1, 64'h0000_0000_FFFF_FFFF, 1'b0},
		'{ROW_KEY,  REG_KEY2, 64'h0000_0000_FFFF_FFFF, 1'b0},
		'{ROW_KEY,  REG_KEY3, 64'h0000_0000_FFFF_FFFF, 1'b0},
		'{ROW_BEAT, REG_KEY0, 64'h0000_0000_0000_0000, 1'b1},
		'{ROW_BEAT, REG_KEY0, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0},
		'{ROW_BEAT, REG_KEY0, 64'h0F0F_0F0F_F0F0_F0F0, 1'b1}
	};

	function automatic logic [BLOCK_W-1:0] decrypt_block(input logic [BLOCK_W-1:0] blk);
		logic [WORD_W-1:0] v0;
		logic [WORD_W-1:0] v1;
		logic [WORD_W-1:0] sum;
		v0 = blk[BLOCK_W-1:WORD_W];
		v1 = blk[WORD_W-1:0];
		sum = WORD_W'(ROUNDS) * TEA_DELTA;
		for (int r = 0; r < ROUNDS; r++) begin
			v1 = v1 - (((v0 << 4) + key_word[REG_KEY2]) ^ (v0 + sum)
				^ ((v0 >> 5) + key_word[REG_KEY3]));
			v0 = v0 - (((v1 << 4) + key_word[REG_KEY0]) ^ (v1 + sum)
				^ ((v1 >> 5) + key_word[REG_KEY1]));
			sum = sum - TEA_DELTA;
		end
		return {v0, v1};
	endfunction

	// entered and left at a falling edge
	task automatic send_block(input logic [BLOCK_W-1:0] blk, input logic last);
		plain_beat_t exp;
		while (!calm && $urandom_range(99) < IDLE_PCT) begin
			in_ch.valid = 1'b0;
			@(negedge clk);
		end
		in_ch.valid = 1'b1;
		in_ch.cipher_block = blk;
		in_ch.last_block = last;
		do
			@(posedge clk);
		while (!in_ch.ready);
		exp.plain = decrypt_block(blk);
		exp.last = last;
		plain_q.push_back(exp);
		blocks_sent++;
		@(negedge clk);
	endtask

	task automatic drain();
		in_ch.valid = 1'b0;
		while (plain_q.size() != 0)
			@(negedge clk);
	endtask

	task automatic write_key(input logic [CFG_IDX_W-1:0] idx, input logic [WORD_W-1:0] val);
		drain();
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		@(posedge clk);
		key_word[idx] = val;
		key_writes++;
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	task automatic write_keys(input logic [WORD_W-1:0] k0, input logic [WORD_W-1:0] k1,
			input logic [WORD_W-1:0] k2, input logic [WORD_W-1:0] k3);
		write_key(REG_KEY0, k0);
		write_key(REG_KEY1, k1);
		write_key(REG_KEY2, k2);
		write_key(REG_KEY3, k3);
		key_sets++;
	endtask

	task automatic report(input string what, input plain_beat_t exp, input plain_beat_t got);
		mismatches++;
		if (mismatches <= MAX_REPORTS)
			$display("%s: expected plain %h last %b, got plain %h last %b",
				what, exp.plain, exp.last, got.plain, got.last);
	endtask

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		out_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			out_ch.ready = calm || ($urandom_range(99) >= IDLE_PCT);
		end
	end

	initial begin
		plain_beat_t got;
		plain_beat_t exp;
		forever begin
			@(posedge clk);
			if (arst_n && out_ch.valid && out_ch.ready) begin
				got.plain = out_ch.plain_block;
				got.last = out_ch.last_out;
				if (plain_q.size() == 0) begin
					exp = '{default: 'x};
					report("unexpected beat", exp, got);
				end else begin
					exp = plain_q.pop_front();
					blocks_checked++;
					if (got.plain !== exp.plain || got.last !== exp.last)
						report("plain block mismatch", exp, got);
				end
			end
		end
	end

	initial begin
		repeat (LIMIT_CYCLES) @(posedge clk);
		$display("timeout after %0d cycles, %0d beats still expected",
			LIMIT_CYCLES, plain_q.size());
		$display("status: fail");
		$finish;
	end

	initial begin
		logic [BLOCK_W-1:0] blk;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_KEY0;
		cfg_data = '0;
		in_ch.valid = 1'b0;
		in_ch.cipher_block = '0;
		in_ch.last_block = 1'b0;
		calm = 1'b0;
		key_word[REG_KEY0] = KEY0_RST;
		key_word[REG_KEY1] = KEY1_RST;
		key_word[REG_KEY2] = KEY2_RST;
		key_word[REG_KEY3] = KEY3_RST;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (directed[i]) begin
			if (directed[i].kind == ROW_KEY)
				write_key(directed[i].key_idx, directed[i].value[WORD_W-1:0]);
			else
				send_block(directed[i].value, directed[i].last);
		end

		for (int p = 0; p < PHASES; p++) begin
			case (p)
				0: write_keys(KEY0_RST, KEY1_RST, KEY2_RST, KEY3_RST);
				3: write_keys(32'h8000_0000, 32'h0000_0001, $urandom & $urandom,
					$urandom | $urandom);
				default: write_keys($urandom, $urandom, $urandom, $urandom);
			endcase
			calm = (p == 2);
			for (int n = 0; n < PHASE_BEATS; n++) begin
				case ($urandom_range(9))
					0: blk = '0;
					1: blk = '1;
					default: blk = {$urandom, $urandom};
				endcase
				send_block(blk, $urandom_range(7) == 0);
			end
			calm = 1'b0;
		end

		drain();
		repeat (2 * ROUNDS + 16) @(posedge clk);
		$display("sent %0d cipher blocks, checked %0d plain blocks, %0d mismatches",
			blocks_sent, blocks_checked, mismatches);
		$display("%0d key register writes over %0d random key sets plus directed zero/ones keys",
			key_writes, key_sets);
		if (mismatches == 0 && plain_q.size() == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end
endmodule
